FILE: rtl/core/pha_pkg.sv
// shared types, widths and codes for the page heap allocator
package pha_pkg;

	localparam int ADDR_W  = 48;
	localparam int BYTES_W = 32;
	localparam int LEN_W   = 11;
	localparam int SIZE_W  = 23;
	localparam int DIV_W   = 33;
	localparam int NEXT_W  = 34;
	localparam int CFG_IDX_W = 2;

	localparam logic [1:0] CMD_ALLOC   = 2'd0;
	localparam logic [1:0] CMD_RELEASE = 2'd1;
	localparam logic [1:0] CMD_QUERY   = 2'd2;

	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_OOM   = 2'd1;
	localparam logic [1:0] STATUS_RANGE = 2'd2;
	localparam logic [1:0] STATUS_FULL  = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_PAGES = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_INIT_COMMIT = 2'd2;

	typedef struct packed {
		logic [1:0]         cmd;
		logic [BYTES_W-1:0] byte_size;
		logic [ADDR_W-1:0]  address;
	} cmd_item_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [ADDR_W-1:0] block_address;
		logic [SIZE_W-1:0] size_bytes;
	} res_item_t;

	typedef struct packed {
		logic [ADDR_W-1:0] pool_base;
		logic [LEN_W-1:0]  total_pages;
		logic              commit_load;
		logic [LEN_W-1:0]  commit_value;
	} cfg_t;

endpackage

FILE: rtl/core/pha_div.sv
// shared shift unit that divides by the page size
module pha_div #(
	parameter int DIVISOR = 4096
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      go,
	input  logic [pha_pkg::DIV_W-1:0] dividend,
	output logic                      done,
	output logic [pha_pkg::DIV_W-1:0] quotient
);

	localparam int SH = $clog2(DIVISOR);

	logic                      done_q;
	logic [pha_pkg::DIV_W-1:0] quot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
			quot_q <= '0;
		end else begin
			done_q <= go;
			if (go) begin
				quot_q <= dividend >> SH;
			end
		end
	end

	assign done     = done_q;
	assign quotient = quot_q;

endmodule

FILE: rtl/core/pha_ctrl.sv
// allocator sequencer with page-length store and free-range list
module pha_ctrl #(
	parameter int MAX_PAGES  = 1024,
	parameter int PAGE_BYTES = 4096
) (
	input  logic               clk,
	input  logic               arst_n,
	input  pha_pkg::cfg_t      cfg,
	input  logic               start,
	input  pha_pkg::cmd_item_t command,
	output logic               busy,
	output logic               done,
	output pha_pkg::res_item_t result
);

	localparam int LW    = pha_pkg::LEN_W;
	localparam int AW    = pha_pkg::ADDR_W;
	localparam int DW    = pha_pkg::DIV_W;
	localparam int NW    = pha_pkg::NEXT_W;
	localparam int PIW   = $clog2(MAX_PAGES);
	localparam int FCW   = $clog2(MAX_PAGES + 1);
	localparam int PBW   = $clog2(PAGE_BYTES + 1);
	localparam int PRODW = LW + PBW;

	typedef struct packed {
		logic [PIW-1:0] start;
		logic [LW-1:0]  count;
	} span_t;

	typedef enum logic [4:0] {
		ST_CLEAR, ST_IDLE, ST_LOC_MUL, ST_LOC_CMP, ST_DIV,
		ST_A_EVAL, ST_SCAN_RD, ST_SCAN_CHK, ST_HIT_RD, ST_HIT_WR,
		ST_GROW1, ST_GROW2, ST_ADDR_MUL, ST_ADDR_ADD,
		ST_REL_RD, ST_REL_WR, ST_Q_RD, ST_Q_OUT
	} state_t;

	state_t             state_q;
	logic [PIW-1:0]     clr_q;
	logic [FCW-1:0]     fc_q;
	logic [FCW-1:0]     scan_q;
	logic [LW-1:0]      bump_q;
	logic [LW-1:0]      committed_q;
	logic [LW-1:0]      blk_q;
	logic [LW-1:0]      short_q;
	logic [1:0]         cmd_q;
	logic [AW-1:0]      addr_q;
	logic [DW-1:0]      q_q;
	logic [PRODW-1:0]   prod_q;
	logic               done_q;
	pha_pkg::res_item_t res_q;

	logic [LW-1:0] pl_mem [MAX_PAGES];
	span_t         fr_mem [MAX_PAGES];
	logic [LW-1:0] pl_rdata_q;
	span_t         fr_rdata_q;

	logic           pl_we;
	logic [PIW-1:0] pl_waddr;
	logic [LW-1:0]  pl_wdata;
	logic [PIW-1:0] pl_raddr;
	logic           fr_we;
	logic [PIW-1:0] fr_waddr;
	span_t          fr_wdata;
	logic [PIW-1:0] fr_raddr;

	logic          div_go;
	logic [DW-1:0] div_num;
	logic          div_done;
	logic [DW-1:0] div_quot;

	logic [LW-1:0] pool;
	logic [LW-1:0] comm;
	logic [LW:0]   remain;
	logic [NW-1:0] next;
	logic [NW-1:0] shortfall;
	logic          bump_ok;
	logic          grow_ok;
	logic          hit;
	logic [LW:0]   dbl;
	logic [LW:0]   grow_max;
	logic [LW:0]   grow;
	logic [AW:0]   pool_end;
	logic          in_range;
	logic [AW-1:0] offset;

	pha_div #(
		.DIVISOR(PAGE_BYTES)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.go      (div_go),
		.dividend(div_num),
		.done    (div_done),
		.quotient(div_quot)
	);

	always_comb begin
		pool      = ({21'b0, cfg.total_pages} < 32'(MAX_PAGES)) ? cfg.total_pages
			: LW'(MAX_PAGES);
		comm      = (committed_q < pool) ? committed_q : pool;
		remain    = {1'b0, pool} - {1'b0, comm};
		next      = NW'(bump_q) + NW'(q_q);
		shortfall = next - NW'(comm);
		bump_ok   = (next < NW'(comm)) && (bump_q < pool);
		grow_ok   = (next >= NW'(comm)) && (bump_q < pool)
			&& (shortfall <= NW'(remain));
		hit       = DW'(fr_rdata_q.count) >= q_q;
		dbl       = {comm, 1'b0};
		grow_max  = ({1'b0, short_q} > dbl) ? {1'b0, short_q} : dbl;
		grow      = (grow_max > remain) ? remain : grow_max;
		pool_end  = {1'b0, cfg.pool_base} + (AW + 1)'(prod_q);
		in_range  = (addr_q >= cfg.pool_base) && ({1'b0, addr_q} < pool_end);
		offset    = addr_q - cfg.pool_base;
	end

	always_comb begin
		pl_we    = 1'b0;
		pl_waddr = PIW'(bump_q);
		pl_wdata = LW'(q_q);
		pl_raddr = q_q[PIW-1:0];
		fr_we    = 1'b0;
		fr_waddr = fc_q[PIW-1:0];
		fr_wdata = '{start: q_q[PIW-1:0], count: pl_rdata_q};
		fr_raddr = scan_q[PIW-1:0];
		div_go   = 1'b0;
		div_num  = DW'(command.byte_size) + DW'(PAGE_BYTES - 1);
		unique case (state_q)
			ST_CLEAR: begin
				pl_we    = 1'b1;
				pl_waddr = clr_q;
				pl_wdata = '0;
			end
			ST_IDLE: begin
				div_go = start && (command.cmd == pha_pkg::CMD_ALLOC);
			end
			ST_LOC_CMP: begin
				div_go  = in_range;
				div_num = offset[DW-1:0];
			end
			ST_A_EVAL: begin
				pl_we = bump_ok;
			end
			ST_SCAN_CHK: begin
				pl_we    = hit;
				pl_waddr = fr_rdata_q.start;
			end
			ST_HIT_RD: begin
				fr_raddr = fc_q[PIW-1:0];
			end
			ST_HIT_WR: begin
				fr_we    = 1'b1;
				fr_waddr = scan_q[PIW-1:0];
				fr_wdata = fr_rdata_q;
			end
			ST_GROW2: begin
				pl_we = 1'b1;
			end
			ST_REL_WR: begin
				fr_we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (pl_we) begin
			pl_mem[pl_waddr] <= pl_wdata;
		end
		pl_rdata_q <= pl_mem[pl_raddr];
	end

	always_ff @(posedge clk) begin
		if (fr_we) begin
			fr_mem[fr_waddr] <= fr_wdata;
		end
		fr_rdata_q <= fr_mem[fr_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			fc_q        <= '0;
			scan_q      <= '0;
			bump_q      <= '0;
			committed_q <= '0;
			done_q      <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == PIW'(MAX_PAGES - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (start) begin
						cmd_q  <= command.cmd;
						addr_q <= command.address;
						unique case (command.cmd)
							pha_pkg::CMD_ALLOC: state_q <= ST_DIV;
							pha_pkg::CMD_RELEASE, pha_pkg::CMD_QUERY: state_q <= ST_LOC_MUL;
							default: begin
								done_q <= 1'b1;
								res_q  <= '0;
							end
						endcase
					end
				end
				ST_LOC_MUL: begin
					prod_q  <= PRODW'(pool) * PRODW'(PAGE_BYTES);
					state_q <= ST_LOC_CMP;
				end
				ST_LOC_CMP: begin
					if (in_range) begin
						state_q <= ST_DIV;
					end else begin
						done_q  <= 1'b1;
						res_q   <= '{status: pha_pkg::STATUS_RANGE, default: '0};
						state_q <= ST_IDLE;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						q_q <= div_quot;
						unique case (cmd_q)
							pha_pkg::CMD_ALLOC:   state_q <= ST_A_EVAL;
							pha_pkg::CMD_RELEASE: state_q <= ST_REL_RD;
							default:              state_q <= ST_Q_RD;
						endcase
					end
				end
				ST_A_EVAL: begin
					committed_q <= comm;
					if (bump_ok) begin
						blk_q   <= bump_q;
						bump_q  <= LW'(next);
						state_q <= ST_ADDR_MUL;
					end else if (fc_q == '0) begin
						state_q <= ST_GROW1;
					end else begin
						scan_q  <= '0;
						state_q <= ST_SCAN_RD;
					end
				end
				ST_SCAN_RD: begin
					state_q <= ST_SCAN_CHK;
				end
				ST_SCAN_CHK: begin
					if (hit) begin
						fc_q    <= fc_q - 1'b1;
						blk_q   <= LW'(fr_rdata_q.start);
						state_q <= ST_HIT_RD;
					end else if (scan_q + 1'b1 == fc_q) begin
						state_q <= ST_GROW1;
					end else begin
						scan_q  <= scan_q + 1'b1;
						state_q <= ST_SCAN_RD;
					end
				end
				ST_HIT_RD: begin
					state_q <= ST_HIT_WR;
				end
				ST_HIT_WR: begin
					state_q <= ST_ADDR_MUL;
				end
				ST_GROW1: begin
					if (grow_ok) begin
						short_q <= LW'(shortfall);
						state_q <= ST_GROW2;
					end else begin
						done_q  <= 1'b1;
						res_q   <= '{status: pha_pkg::STATUS_OOM, default: '0};
						state_q <= ST_IDLE;
					end
				end
				ST_GROW2: begin
					committed_q <= comm + LW'(grow);
					blk_q       <= bump_q;
					bump_q      <= LW'(next);
					state_q     <= ST_ADDR_MUL;
				end
				ST_ADDR_MUL: begin
					prod_q  <= PRODW'(blk_q) * PRODW'(PAGE_BYTES);
					state_q <= ST_ADDR_ADD;
				end
				ST_ADDR_ADD: begin
					done_q  <= 1'b1;
					res_q   <= '{status: pha_pkg::STATUS_OK,
						block_address: cfg.pool_base + AW'(prod_q), size_bytes: '0};
					state_q <= ST_IDLE;
				end
				ST_REL_RD: begin
					if (fc_q == FCW'(MAX_PAGES)) begin
						done_q  <= 1'b1;
						res_q   <= '{status: pha_pkg::STATUS_FULL, default: '0};
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_REL_WR;
					end
				end
				ST_REL_WR: begin
					fc_q    <= fc_q + 1'b1;
					done_q  <= 1'b1;
					res_q   <= '{status: pha_pkg::STATUS_OK, default: '0};
					state_q <= ST_IDLE;
				end
				ST_Q_RD: begin
					state_q <= ST_Q_OUT;
				end
				ST_Q_OUT: begin
					done_q  <= 1'b1;
					res_q   <= '{status: pha_pkg::STATUS_OK, block_address: '0,
						size_bytes: pha_pkg::SIZE_W'(PRODW'(pl_rdata_q) * PRODW'(PAGE_BYTES))};
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (cfg.commit_load) begin
				committed_q <= cfg.commit_value;
			end
		end
	end

	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign result = res_q;

endmodule

FILE: rtl/core/page_heap_allocator.sv
// top level: configuration registers and the allocator sequencer
//
// Whole-page heap allocator. A command is taken when start is high and busy
// is low; its single result appears on result for one cycle with done high
// and must be taken then, as nothing holds it. Byte counts and offsets are
// turned into pages by one shared shift unit, so PAGE_BYTES must be a power
// of two; the block itself does not check it. An allocate takes the bump
// path, else scans the free list entry by entry, else grows the commit,
// and answers out of memory when it cannot grow. A release or size query
// answers early when the address lies outside the pool, as does a release
// onto a full free list; an unused command answers from idle. Busy drops
// with the result, so the next command can be taken while done is high.
// After reset the page-length store is swept to zero, one entry a cycle,
// over all MAX_PAGES entries with busy high; register writes are taken
// during that sweep. Registers are to be written only while busy is low
// and no result is pending; the block itself does not enforce it.
module page_heap_allocator #(
	parameter int MAX_PAGES  = 1024,
	parameter int PAGE_BYTES = 4096
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [pha_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [pha_pkg::ADDR_W-1:0]    cfg_wdata,
	input  logic                          start,
	input  pha_pkg::cmd_item_t            command,
	output logic                          busy,
	output logic                          done,
	output pha_pkg::res_item_t            result
);

	logic [pha_pkg::ADDR_W-1:0] pool_base_q;
	logic [pha_pkg::LEN_W-1:0]  total_pages_q;
	pha_pkg::cfg_t              cfg;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_base_q   <= '0;
			total_pages_q <= pha_pkg::LEN_W'(1024);
		end else if (cfg_we) begin
			if (cfg_index == pha_pkg::CFG_POOL_BASE) begin
				pool_base_q <= cfg_wdata;
			end
			if (cfg_index == pha_pkg::CFG_TOTAL_PAGES) begin
				total_pages_q <= cfg_wdata[pha_pkg::LEN_W-1:0];
			end
		end
	end

	assign cfg = '{
		pool_base:    pool_base_q,
		total_pages:  total_pages_q,
		commit_load:  cfg_we && (cfg_index == pha_pkg::CFG_INIT_COMMIT),
		commit_value: cfg_wdata[pha_pkg::LEN_W-1:0]
	};

	pha_ctrl #(
		.MAX_PAGES (MAX_PAGES),
		.PAGE_BYTES(PAGE_BYTES)
	) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.start  (start),
		.command(command),
		.busy   (busy),
		.done   (done),
		.result (result)
	);

endmodule

FILE: tb/testbench.sv
// testbench for the page heap allocator: directed and random commands checked by a predictor
module testbench;

	localparam int NPAGES    = 1024;
	localparam int PAGE_SZ   = 4096;
	localparam int HOLE_SOFT = 48;

	localparam logic [1:0]                    CMD_UNUSED = 2'd3;
	localparam logic [pha_pkg::CFG_IDX_W-1:0] CFG_SPARE  = 2'd3;

	logic                          clk       = 1'b0;
	logic                          arst_n    = 1'b0;
	logic                          cfg_we    = 1'b0;
	logic [pha_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [pha_pkg::ADDR_W-1:0]    cfg_wdata = '0;
	logic                          start     = 1'b0;
	pha_pkg::cmd_item_t            command   = '0;
	logic                          busy;
	logic                          done;
	pha_pkg::res_item_t            result;

	// predicted allocator state
	logic [pha_pkg::ADDR_W-1:0] pool_origin    = '0;
	int unsigned                reserve_pages  = NPAGES;
	int unsigned                commit_now     = 0;
	int unsigned                next_free_page = 0;
	int unsigned                hole_count     = 0;
	logic [pha_pkg::LEN_W-1:0]  len_of_page [NPAGES];
	int unsigned                hole_page [NPAGES];
	int unsigned                hole_len [NPAGES];

	pha_pkg::cmd_item_t cmd_backlog[$];
	pha_pkg::res_item_t answers_due[$];
	int unsigned        owned_pages[$];
	int unsigned        gap_left   = 0;
	bit                 idle_on    = 1'b1;
	int unsigned        bad_fields = 0;

	page_heap_allocator #(
		.MAX_PAGES(NPAGES),
		.PAGE_BYTES(PAGE_SZ)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.start(start),
		.command(command),
		.busy(busy),
		.done(done),
		.result(result)
	);

	always #5 clk = ~clk;

	function automatic int unsigned pool_pages();
		return (reserve_pages < NPAGES) ? reserve_pages : NPAGES;
	endfunction

	function automatic logic [pha_pkg::ADDR_W-1:0] page_to_addr(int unsigned pg);
		longint unsigned a;
		a = pool_origin;
		a = a + longint'(pg) * PAGE_SZ;
		return a[pha_pkg::ADDR_W-1:0];
	endfunction

	function automatic logic [pha_pkg::ADDR_W-1:0] grant(int unsigned pg, longint unsigned req);
		len_of_page[pg] = req[pha_pkg::LEN_W-1:0];
		owned_pages.push_back(pg);
		return page_to_addr(pg);
	endfunction

	function automatic pha_pkg::res_item_t settle_command(pha_pkg::cmd_item_t c);
		pha_pkg::res_item_t r;
		longint unsigned    span, lim, req, nxt, top, room, grow, addr, base, sz;
		int unsigned        k, pg;
		bit                 hit;
		r    = '0;
		span = pool_pages();
		base = pool_origin;
		addr = c.address;
		top  = base + span * PAGE_SZ;
		hit  = 1'b0;
		case (c.cmd)
		pha_pkg::CMD_ALLOC: begin
			lim = (commit_now < span) ? commit_now : span;
			commit_now = 32'(lim);
			req = c.byte_size;
			req = (req + PAGE_SZ - 1) / PAGE_SZ;
			nxt = next_free_page + req;
			if (nxt < lim && next_free_page < span) begin
				r.block_address = grant(next_free_page, req);
				next_free_page = 32'(nxt);
				hit = 1'b1;
			end
			for (k = 0; k < hole_count && !hit; k++) begin
				if (hole_len[k] >= req) begin
					r.block_address = grant(hole_page[k] % NPAGES, req);
					hole_count--;
					hole_page[k] = hole_page[hole_count];
					hole_len[k] = hole_len[hole_count];
					hit = 1'b1;
				end
			end
			if (!hit && nxt >= lim && next_free_page < span && nxt - lim <= span - lim) begin
				room = span - lim;
				grow = 2 * lim;
				if (nxt - lim > grow)
					grow = nxt - lim;
				if (grow > room)
					grow = room;
				commit_now = 32'(lim + grow);
				r.block_address = grant(next_free_page, req);
				next_free_page = 32'(nxt);
				hit = 1'b1;
			end
			if (!hit)
				r.status = pha_pkg::STATUS_OOM;
		end
		pha_pkg::CMD_RELEASE: begin
			if (addr < base || addr >= top) begin
				r.status = pha_pkg::STATUS_RANGE;
			end else if (hole_count >= NPAGES) begin
				r.status = pha_pkg::STATUS_FULL;
			end else begin
				pg = 32'((addr - base) / PAGE_SZ);
				hole_page[hole_count] = pg;
				hole_len[hole_count] = len_of_page[pg];
				hole_count++;
			end
		end
		pha_pkg::CMD_QUERY: begin
			if (addr < base || addr >= top) begin
				r.status = pha_pkg::STATUS_RANGE;
			end else begin
				pg = 32'((addr - base) / PAGE_SZ);
				sz = len_of_page[pg];
				sz = sz * PAGE_SZ;
				r.size_bytes = sz[pha_pkg::SIZE_W-1:0];
			end
		end
		default: ;
		endcase
		return r;
	endfunction

	function automatic logic [pha_pkg::ADDR_W-1:0] any_address();
		logic [15:0] hi;
		hi = 16'($urandom_range(0, 16'hFFFF));
		return {hi, $urandom()};
	endfunction

	function automatic pha_pkg::cmd_item_t draw_command();
		pha_pkg::cmd_item_t c;
		int unsigned        roll, j, pg;
		c.cmd       = pha_pkg::CMD_ALLOC;
		c.byte_size = $urandom();
		c.address   = any_address();
		roll        = $urandom_range(0, 99);
		if (roll < 45) begin
			case ($urandom_range(0, 9))
			0: c.byte_size = $urandom();
			1, 2: c.byte_size = $urandom_range(0, 16) * PAGE_SZ;
			3: c.byte_size = $urandom_range(0, 16 * PAGE_SZ);
			default: c.byte_size = $urandom_range(0, 3 * PAGE_SZ);
			endcase
		end else if (roll < 93) begin
			c.cmd = (roll < 75) ? pha_pkg::CMD_RELEASE : pha_pkg::CMD_QUERY;
			if (c.cmd == pha_pkg::CMD_RELEASE && hole_count >= HOLE_SOFT)
				c.cmd = pha_pkg::CMD_QUERY;
			if (roll % 8 != 0) begin
				if (owned_pages.size() > 0 && roll % 3 != 0) begin
					j  = $urandom_range(0, owned_pages.size() - 1);
					pg = owned_pages[j];
					if (c.cmd == pha_pkg::CMD_RELEASE)
						owned_pages.delete(j);
				end else begin
					pg = $urandom_range(0, pool_pages() - 1);
				end
				c.address = page_to_addr(pg) + (roll[0] ? $urandom_range(0, PAGE_SZ - 1) : 0);
			end
		end else begin
			c.cmd = CMD_UNUSED;
		end
		return c;
	endfunction

	task automatic push_cmd(logic [1:0] op, logic [pha_pkg::BYTES_W-1:0] nbytes,
			logic [pha_pkg::ADDR_W-1:0] addr);
		pha_pkg::cmd_item_t c;
		c.cmd       = op;
		c.byte_size = nbytes;
		c.address   = addr;
		cmd_backlog.push_back(c);
	endtask

	task automatic write_reg(logic [pha_pkg::CFG_IDX_W-1:0] idx,
			logic [pha_pkg::ADDR_W-1:0] data);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
		pha_pkg::CFG_POOL_BASE: pool_origin = data;
		pha_pkg::CFG_TOTAL_PAGES: reserve_pages = data[pha_pkg::LEN_W-1:0];
		pha_pkg::CFG_INIT_COMMIT: commit_now = data[pha_pkg::LEN_W-1:0];
		default: ;
		endcase
	endtask

	task automatic drain();
		while (cmd_backlog.size() != 0 || answers_due.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic run_phase(logic [pha_pkg::ADDR_W-1:0] base, int unsigned total,
			int unsigned commit, int unsigned n, bit idle);
		logic [pha_pkg::ADDR_W-1:0] w;
		int unsigned                made;
		drain();
		write_reg(pha_pkg::CFG_POOL_BASE, base);
		w = any_address();
		w[pha_pkg::LEN_W-1:0] = pha_pkg::LEN_W'(total);
		write_reg(pha_pkg::CFG_TOTAL_PAGES, w);
		w = any_address();
		w[pha_pkg::LEN_W-1:0] = pha_pkg::LEN_W'(commit);
		write_reg(pha_pkg::CFG_INIT_COMMIT, w);
		write_reg(CFG_SPARE, any_address());
		idle_on = idle;
		made = 0;
		while (made < n) begin
			if (cmd_backlog.size() < 4) begin
				cmd_backlog.push_back(draw_command());
				made++;
			end else begin
				@(negedge clk);
			end
		end
	endtask

	always @(posedge clk) begin
		if (start && !busy) begin
			answers_due.push_back(settle_command(command));
			cmd_backlog.delete(0);
		end
		if (gap_left > 0)
			gap_left--;
		else if (idle_on && $urandom_range(0, 7) == 0)
			gap_left = $urandom_range(1, 4);
		if (gap_left == 0 && cmd_backlog.size() > 0) begin
			start   <= 1'b1;
			command <= cmd_backlog[0];
		end else begin
			start <= 1'b0;
		end
	end

	always @(posedge clk) begin : check
		pha_pkg::res_item_t want;
		if (done === 1'b1) begin
			if (answers_due.size() == 0) begin
				$display("%0t: result with none expected: expected nothing got %h", $time, result);
				bad_fields++;
			end else begin
				want = answers_due.pop_front();
				if (result.status !== want.status) begin
					$display("%0t: status expected %0d got %0d", $time, want.status,
						result.status);
					bad_fields++;
				end
				if (result.block_address !== want.block_address) begin
					$display("%0t: block_address expected %h got %h", $time,
						want.block_address, result.block_address);
					bad_fields++;
				end
				if (result.size_bytes !== want.size_bytes) begin
					$display("%0t: size_bytes expected %0d got %0d", $time, want.size_bytes,
						result.size_bytes);
					bad_fields++;
				end
			end
		end
	end

	initial begin : stimulus
		int unsigned need, k;
		for (k = 0; k < NPAGES; k++) begin
			len_of_page[k] = '0;
			hole_page[k] = 0;
			hole_len[k] = 0;
		end
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		write_reg(pha_pkg::CFG_POOL_BASE, '0);
		write_reg(pha_pkg::CFG_TOTAL_PAGES, NPAGES);
		write_reg(pha_pkg::CFG_INIT_COMMIT, '0);

		// growth from nothing, then a free list hit
		push_cmd(pha_pkg::CMD_ALLOC, 1, '0);
		push_cmd(pha_pkg::CMD_RELEASE, '0, '0);
		push_cmd(pha_pkg::CMD_ALLOC, PAGE_SZ, '1);
		push_cmd(pha_pkg::CMD_ALLOC, 0, '0);
		push_cmd(pha_pkg::CMD_ALLOC, PAGE_SZ + 1, '0);
		push_cmd(pha_pkg::CMD_ALLOC, 2 * PAGE_SZ, '0);
		// oversized requests, then queries inside and outside the pool
		push_cmd(pha_pkg::CMD_ALLOC, '1, '0);
		push_cmd(pha_pkg::CMD_ALLOC, NPAGES * PAGE_SZ, '0);
		push_cmd(pha_pkg::CMD_QUERY, '0, PAGE_SZ + 7);
		push_cmd(pha_pkg::CMD_QUERY, '0, (NPAGES - 1) * PAGE_SZ);
		push_cmd(pha_pkg::CMD_QUERY, '0, NPAGES * PAGE_SZ);
		push_cmd(pha_pkg::CMD_QUERY, '1, '1);
		// unaligned, repeated, never written and out-of-range releases, unused commands, then an allocate and a query
		push_cmd(pha_pkg::CMD_RELEASE, '0, 3 * PAGE_SZ + 123);
		push_cmd(pha_pkg::CMD_RELEASE, '0, 3 * PAGE_SZ);
		push_cmd(pha_pkg::CMD_RELEASE, '0, 700 * PAGE_SZ);
		push_cmd(pha_pkg::CMD_RELEASE, '0, '1);
		push_cmd(CMD_UNUSED, '1, '1);
		push_cmd(CMD_UNUSED, '0, '0);
		push_cmd(pha_pkg::CMD_ALLOC, 4 * PAGE_SZ, '0);
		push_cmd(pha_pkg::CMD_QUERY, '0, 3 * PAGE_SZ + PAGE_SZ - 1);

		run_phase(any_address() & ~48'hFFF, NPAGES, NPAGES, 150, 1'b1);
		run_phase('1, 1, 2047, 100, 1'b1);
		run_phase(any_address(), $urandom_range(1, NPAGES), $urandom_range(0, NPAGES), 150, 1'b1);
		run_phase('0, 2047, 0, 150, 1'b1);
		run_phase(any_address(), NPAGES, $urandom_range(0, 2047), 150, 1'b1);
		run_phase(any_address() & ~48'hFFF, $urandom_range(1, NPAGES), 0, 150, 1'b1);
		run_phase(any_address() & ~48'hFFF, NPAGES, NPAGES, 100, 1'b0);

		// fill the free list past full, then scan it
		run_phase('0, NPAGES, 0, 0, 1'b0);
		need = NPAGES + 3 - hole_count;
		for (k = 0; k < need; k++)
			push_cmd(pha_pkg::CMD_RELEASE, $urandom(),
				page_to_addr($urandom_range(0, NPAGES - 1)));
		push_cmd(pha_pkg::CMD_ALLOC, 0, '0);
		push_cmd(pha_pkg::CMD_ALLOC, '1, '0);
		push_cmd(pha_pkg::CMD_RELEASE, '0, page_to_addr(5));
		push_cmd(pha_pkg::CMD_RELEASE, '0, page_to_addr(6));

		drain();
		repeat (64) @(negedge clk);
		if (bad_fields == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#50000000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
